>>> src/dvle_pkg.sv
// ----------------------------------------------------------------------------
// dvle_pkg: shared types and constants for the delta varint list encoder
// Holds the job record passed from the front part to the back part, the
// status codes and the sizing constants of the block.
// ----------------------------------------------------------------------------
package dvle_pkg;

   // Width of the saturating entry counter (8 to 64).
   localparam int COUNT_BITS = 32;

   // Field widths of the transactions.
   localparam int VALUE_BITS = 64;
   localparam int ENTRY_BITS = 32;
   localparam int BYTE_BITS  = 8;

   // Depth of the job queue between front and back.
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_FILL_BITS = $clog2(QUEUE_DEPTH + 1);

   // Bytes left after the first one, at most seven.
   localparam int REMAIN_BITS = 3;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   typedef enum logic [1:0] {
      STATUS_OK             = 2'd0,
      STATUS_NOT_INCREASING = 2'd1,
      STATUS_RESERVED       = 2'd2,
      STATUS_TOO_LARGE      = 2'd3
   } status_type;

   // Length code: log2 of the byte count.
   typedef enum logic [1:0] {
      LEN_1_BYTE  = 2'd0,
      LEN_2_BYTES = 2'd1,
      LEN_4_BYTES = 2'd2,
      LEN_8_BYTES = 2'd3
   } len_code_type;

   // One accepted value, ready to be serialized.
   typedef struct packed {
      logic [VALUE_BITS-1:0]  word;
      logic [REMAIN_BITS-1:0] remain;
      status_type             status;
      logic [ENTRY_BITS-1:0]  entry_count;
      logic [VALUE_BITS-1:0]  largest_value;
   } job_type;

endpackage

>>> src/dvle_front.sv
// ----------------------------------------------------------------------------
// dvle_front: list state, checks and delta formatting
// Accepts one value per cycle while accept is high, checks it against
// the list state, updates it and builds the packed word the back serializes.
// ----------------------------------------------------------------------------
module dvle_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [dvle_pkg::VALUE_BITS-1:0] value,
   input  logic                        start_new_list,
   output dvle_pkg::job_type           job
);

   dvle_pkg::value_type prev_ff, prev_in;
   logic                nonempty_ff, nonempty_in;
   dvle_pkg::count_type count_ff, count_in;

   dvle_pkg::value_type base_prev;
   logic                base_nonempty;
   dvle_pkg::count_type base_count;
   dvle_pkg::value_type delta;
   logic                is_reserved;
   logic                not_increasing;
   logic                too_large;
   dvle_pkg::len_code_type code;
   dvle_pkg::status_type   status;
   logic [63:0]            count_wide;

   always_comb begin
      // apply the clear first
      base_prev     = start_new_list ? '0 : prev_ff;
      base_nonempty = start_new_list ? 1'b0 : nonempty_ff;
      base_count    = start_new_list ? '0 : count_ff;

      delta          = value - base_prev;
      is_reserved    = &value;
      not_increasing = base_nonempty && (value <= base_prev);
      too_large      = |delta[63:62];

      if (is_reserved) begin
         status = dvle_pkg::STATUS_RESERVED;
      end else if (not_increasing) begin
         status = dvle_pkg::STATUS_NOT_INCREASING;
      end else if (too_large) begin
         status = dvle_pkg::STATUS_TOO_LARGE;
      end else begin
         status = dvle_pkg::STATUS_OK;
      end

      if (delta[63:6] == '0) begin
         code = dvle_pkg::LEN_1_BYTE;
      end else if (delta[63:14] == '0) begin
         code = dvle_pkg::LEN_2_BYTES;
      end else if (delta[63:30] == '0) begin
         code = dvle_pkg::LEN_4_BYTES;
      end else begin
         code = dvle_pkg::LEN_8_BYTES;
      end

      prev_in     = base_prev;
      nonempty_in = base_nonempty;
      count_in    = base_count;
      if (status == dvle_pkg::STATUS_OK) begin
         prev_in     = value;
         nonempty_in = 1'b1;
         if (base_count != '1) begin
            count_in = base_count + {{(dvle_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
         end
      end

      count_wide = 64'(count_in);

      job.status        = status;
      job.entry_count   = count_wide[dvle_pkg::ENTRY_BITS-1:0];
      // previous value is zero whenever the list is empty
      job.largest_value = prev_in;
      if (status == dvle_pkg::STATUS_OK) begin
         job.word = {delta[61:6], code, delta[5:0]};
         case (code)
            dvle_pkg::LEN_1_BYTE:  job.remain = 3'd0;
            dvle_pkg::LEN_2_BYTES: job.remain = 3'd1;
            dvle_pkg::LEN_4_BYTES: job.remain = 3'd3;
            dvle_pkg::LEN_8_BYTES: job.remain = 3'd7;
            default:               job.remain = 3'd0;
         endcase
      end else begin
         job.word   = '0;
         job.remain = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         nonempty_ff <= 1'b0;
         count_ff    <= '0;
      end else if (accept) begin
         prev_ff     <= prev_in;
         nonempty_ff <= nonempty_in;
         count_ff    <= count_in;
      end
   end

   a_empty_prev_zero: assert property (@(posedge clock) disable iff (reset)
      !nonempty_ff |-> (prev_ff == '0))
      else $error("previous value nonzero while list empty");

   a_count_moves_with_list: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> nonempty_ff)
      else $error("entries counted on an empty list");

endmodule

>>> src/dvle_queue.sv
// ----------------------------------------------------------------------------
// dvle_queue: short job queue between front and back
// Holds formatted jobs so the front accepts while the back drains, until full.
// ----------------------------------------------------------------------------
module dvle_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dvle_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output dvle_pkg::job_type head_job
);

   dvle_pkg::job_type entries_ff [dvle_pkg::QUEUE_DEPTH];
   logic [dvle_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [dvle_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [dvle_pkg::QUEUE_FILL_BITS-1:0] fill_ff, fill_in;
   logic do_push;
   logic do_pop;

   localparam logic [dvle_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
      dvle_pkg::QUEUE_PTR_BITS'(dvle_pkg::QUEUE_DEPTH - 1);
   localparam logic [dvle_pkg::QUEUE_FILL_BITS-1:0] DEPTH_FILL =
      dvle_pkg::QUEUE_FILL_BITS'(dvle_pkg::QUEUE_DEPTH);

   assign full     = (fill_ff == DEPTH_FILL);
   assign empty    = (fill_ff == '0);
   assign head_job = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_FILL)
      else $error("job queue over capacity");

endmodule

>>> src/dvle_back.sv
// ----------------------------------------------------------------------------
// dvle_back: byte serializer
// Takes jobs from the queue and presents their bytes one per transaction,
// low byte first.
// ----------------------------------------------------------------------------
module dvle_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_ready,
   input  dvle_pkg::job_type job,
   output logic              job_take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [dvle_pkg::BYTE_BITS-1:0]  rsp_out_byte,
   output logic              rsp_last_of_run,
   output logic [1:0]        rsp_status,
   output logic [dvle_pkg::ENTRY_BITS-1:0] rsp_entry_count,
   output logic [dvle_pkg::VALUE_BITS-1:0] rsp_largest_value
);

   dvle_pkg::job_type cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic              taken;
   logic              is_last;

   assign is_last  = (cur_ff.remain == '0);
   assign taken    = busy_ff && rsp_pop;
   assign job_take = job_ready && (!busy_ff || (taken && is_last));

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      if (job_take) begin
         cur_in  = job;
         busy_in = 1'b1;
      end else if (taken) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            // advance to the next byte
            cur_in.word   = cur_ff.word >> dvle_pkg::BYTE_BITS;
            cur_in.remain = cur_ff.remain - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_empty         = !busy_ff;
   assign rsp_out_byte      = cur_ff.word[dvle_pkg::BYTE_BITS-1:0];
   assign rsp_last_of_run   = is_last;
   assign rsp_status        = cur_ff.status;
   assign rsp_entry_count   = cur_ff.entry_count;
   assign rsp_largest_value = cur_ff.largest_value;

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (taken && !is_last) |=> busy_ff)
      else $error("byte run dropped before its last byte");

   a_error_single_byte: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (cur_ff.status != dvle_pkg::STATUS_OK)) |-> is_last)
      else $error("rejected value produced more than one byte");

endmodule

>>> src/delta_varint_list_encoder.sv
// ----------------------------------------------------------------------------
// delta_varint_list_encoder: delta encoding of an increasing list into
// prefix varint bytes
// Each valid value becomes its delta from the previous value, sent as
// 1, 2, 4 or 8 little-endian bytes, length code in bits 7:6 of the first byte.
//
//   channel  direction  handshake        payload
//   req      in         push / full      value, start_new_list
//   rsp      out        pop / empty      out_byte, last_of_run, status,
//                                        entry_count, largest_value
//
// A value is taken in any cycle in which the job queue has room: the front
// checks it, updates the list state and formats it in that cycle.
// The first byte reaches rsp through the queue and the serializer register;
// the back then gives one byte per cycle while rsp is popped, through the
// single byte-wide result port, so a value takes 1, 2, 4 or 8 bytes.
// Up to two formatted jobs plus the one in the serializer wait at a time.
// Reset is synchronous and clears the list state, the queue and the
// serializer; a stalled rsp holds its byte and backs up into full.
// ----------------------------------------------------------------------------
module delta_varint_list_encoder (
   input  logic        clock,
   input  logic        reset,
   // request queue
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_value,
   input  logic        req_start_new_list,
   // response queue
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_entry_count,
   output logic [63:0] rsp_largest_value
);

   logic              req_accept;
   dvle_pkg::job_type front_job;
   dvle_pkg::job_type head_job;
   logic              queue_empty;
   logic              queue_take;

   // A transaction on req goes straight to the front and into the queue.
   assign req_accept = req_push && !req_full;

   dvle_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .value          (req_value),
      .start_new_list (req_start_new_list),
      .job            (front_job)
   );

   // Decouple checking from serializing; the input stalls only on a full queue.
   dvle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_job (front_job),
      .full     (req_full),
      .pop      (queue_take),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   // Hold the current job and advance one byte per rsp transaction.
   dvle_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_ready         (!queue_empty),
      .job               (head_job),
      .job_take          (queue_take),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_largest_value (rsp_largest_value)
   );

endmodule

>>> test/delta_varint_list_encoder_tb.sv
// ----------------------------------------------------------------------------
// delta_varint_list_encoder_tb: self-checking bench for the delta varint
// list encoder
// Feeds increasing value lists, plus broken and reserved values, through the
// push/full side. It predicts every encoded byte with a behavioral model of
// the list state and compares each popped transaction field by field. Both
// sides are paced at random in three phases.
// ----------------------------------------------------------------------------
module delta_varint_list_encoder_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam dvle_pkg::value_type ALL_ONES = '1;
   localparam dvle_pkg::value_type DELTA_LIMIT = 64'h4000_0000_0000_0000;

   // One encoded byte as it should leave the block.
   typedef struct packed {
      logic [7:0]           data;
      logic                 last;
      dvle_pkg::status_type status;
      logic [31:0]          count;
      dvle_pkg::value_type  largest;
   } enc_byte_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   dvle_pkg::value_type req_value = '0;
   logic                req_start_new_list = 1'b0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [7:0]          rsp_out_byte;
   logic                rsp_last_of_run;
   logic [1:0]          rsp_status;
   logic [31:0]         rsp_entry_count;
   dvle_pkg::value_type rsp_largest_value;

   // Predicted list state, advanced once per accepted value.
   dvle_pkg::value_type list_prev = '0;
   logic                list_open = 1'b0;
   dvle_pkg::count_type list_entries = '0;

   enc_byte_type pending_bytes[$];
   enc_byte_type want_byte;

   int          push_idle_pct = 21;
   int          pop_idle_pct = 50;
   int          fail_count = 0;
   int          values_sent = 0;
   int          bytes_checked = 0;
   int          rejected_count[4] = '{0, 0, 0, 0};
   int          cycle_count = 0;

   delta_varint_list_encoder uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_value         (req_value),
      .req_start_new_list(req_start_new_list),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_largest_value (rsp_largest_value)
   );

   always #10 clock = ~clock;

   // Stop a hung run: a stuck full or empty must not hang the simulator.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d bytes still pending",
                  cycle_count, pending_bytes.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Queue one predicted byte, tagged with the list state as it stands now.
   function automatic void queue_byte(input logic [7:0] data, input logic last,
                                      input dvle_pkg::status_type status);
      enc_byte_type item;
      item.data    = data;
      item.last    = last;
      item.status  = status;
      item.count   = 32'(list_entries);
      item.largest = list_open ? list_prev : '0;
      pending_bytes.push_back(item);
   endfunction

   // Predict the bytes of one accepted value and advance the list state.
   function automatic void predict_encoding(input dvle_pkg::value_type value,
                                            input logic start);
      dvle_pkg::value_type    delta;
      dvle_pkg::value_type    word;
      dvle_pkg::len_code_type code;
      dvle_pkg::status_type   verdict;
      int                     nbytes;
      // A start flag clears the list even when the value is then rejected.
      if (start) begin
         list_prev    = '0;
         list_open    = 1'b0;
         list_entries = '0;
      end
      delta   = value - (list_open ? list_prev : '0);
      verdict = dvle_pkg::STATUS_OK;
      // Check in priority order: reserved, then ordering, then delta range.
      if (value == ALL_ONES)
         verdict = dvle_pkg::STATUS_RESERVED;
      else if (list_open && value <= list_prev)
         verdict = dvle_pkg::STATUS_NOT_INCREASING;
      else if (delta >= DELTA_LIMIT)
         verdict = dvle_pkg::STATUS_TOO_LARGE;
      if (verdict != dvle_pkg::STATUS_OK) begin
         rejected_count[verdict]++;
         queue_byte(8'h00, 1'b1, verdict);
         return;
      end
      if (delta[63:6] == '0)
         code = dvle_pkg::LEN_1_BYTE;
      else if (delta[63:14] == '0)
         code = dvle_pkg::LEN_2_BYTES;
      else if (delta[63:30] == '0)
         code = dvle_pkg::LEN_4_BYTES;
      else
         code = dvle_pkg::LEN_8_BYTES;
      nbytes = 1 << code;
      // Length code sits between the low six delta bits and the rest.
      word = {delta[61:6], code, delta[5:0]};
      list_prev = value;
      list_open = 1'b1;
      if (list_entries != '1)
         list_entries++;
      for (int k = 0; k < nbytes; k++)
         queue_byte(word[8*k +: 8], k == nbytes - 1, dvle_pkg::STATUS_OK);
   endfunction

   // Push one value: idle at random first, then hold it until taken.
   task automatic send_value(input dvle_pkg::value_type value, input logic start);
      while ($urandom_range(99) < push_idle_pct) begin
         @(negedge clock);
         req_push  <= 1'b0;
         req_value <= {$urandom, $urandom};
         req_start_new_list <= 1'($urandom_range(1));
      end
      @(negedge clock);
      req_push  <= 1'b1;
      req_value <= value;
      req_start_new_list <= start;
      do @(posedge clock); while (req_full);
      predict_encoding(value, start);
      values_sent++;
   endtask

   // Drive pop at the falling edge; the pacing follows the current phase.
   always @(negedge clock)
      rsp_pop <= ($urandom_range(99) >= pop_idle_pct);

   // Compare each popped transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected byte %h popped with nothing pending", rsp_out_byte);
            fail_count++;
         end else begin
            want_byte = pending_bytes.pop_front();
            bytes_checked++;
            if (rsp_out_byte !== want_byte.data) begin
               $error("out_byte: expected %h, got %h", want_byte.data, rsp_out_byte);
               fail_count++;
            end
            if (rsp_last_of_run !== want_byte.last) begin
               $error("last_of_run: expected %b, got %b", want_byte.last,
                      rsp_last_of_run);
               fail_count++;
            end
            if (rsp_status !== want_byte.status) begin
               $error("status: expected %0d, got %0d", want_byte.status, rsp_status);
               fail_count++;
            end
            if (rsp_entry_count !== want_byte.count) begin
               $error("entry_count: expected %0d, got %0d", want_byte.count,
                      rsp_entry_count);
               fail_count++;
            end
            if (rsp_largest_value !== want_byte.largest) begin
               $error("largest_value: expected %h, got %h", want_byte.largest,
                      rsp_largest_value);
               fail_count++;
            end
         end
      end
   end

   // Hit each length boundary, every rejection and the clear paths.
   task automatic test_edge_cases();
      dvle_pkg::value_type v;
      send_value(64'd0, 1'b1);                  // first value zero, one byte
      send_value(64'd0, 1'b0);                  // repeat of the last value
      send_value(64'd63, 1'b0);                 // largest one-byte delta
      send_value(64'd127, 1'b0);                // smallest two-byte delta
      v = 64'd127 + 64'h3fff;
      send_value(v, 1'b0);                      // largest two-byte delta
      v = v + 64'h4000;
      send_value(v, 1'b0);                      // smallest four-byte delta
      v = v + 64'h3fff_ffff;
      send_value(v, 1'b0);                      // largest four-byte delta
      v = v + 64'h4000_0000;
      send_value(v, 1'b0);                      // smallest eight-byte delta
      v = v + DELTA_LIMIT - 1;
      send_value(v, 1'b0);                      // largest legal delta
      send_value(v + DELTA_LIMIT, 1'b0);        // delta just too large
      send_value(v - 1, 1'b0);                  // decrease wins over wrapped delta
      send_value(ALL_ONES, 1'b0);               // reserved value on an open list
      send_value(ALL_ONES, 1'b1);               // reserved, clear still applies
      send_value(ALL_ONES - 1, 1'b0);           // empty list, delta too large
      send_value(64'd5, 1'b0);                  // delta from zero after clear
      send_value(DELTA_LIMIT, 1'b1);            // start with a rejected value
      send_value(DELTA_LIMIT - 1, 1'b1);        // start with the largest delta
      // Walk the list up to the top of the value range.
      v = DELTA_LIMIT - 1;
      v = v + DELTA_LIMIT - 1;
      send_value(v, 1'b0);
      v = v + DELTA_LIMIT - 1;
      send_value(v, 1'b0);
      v = v + DELTA_LIMIT - 1;
      send_value(v, 1'b0);                      // lands on all-ones minus three
      send_value(ALL_ONES - 1, 1'b0);           // largest storable value
      send_value(ALL_ONES, 1'b0);               // reserved although it increases the list
   endtask

   // Mostly well-formed lists with random deltas, plus a share of noise.
   task automatic test_random_lists(input int count, input int push_pct,
                                    input int pop_pct);
      dvle_pkg::value_type delta;
      dvle_pkg::value_type base;
      dvle_pkg::value_type value;
      logic                start;
      int                  pick;
      push_idle_pct = push_pct;
      pop_idle_pct  = pop_pct;
      for (int n = 0; n < count; n++) begin
         // Restart near the top so well-formed lists keep encoding.
         start = ($urandom_range(99) < 4) || (list_open && list_prev[63]);
         base  = (start || !list_open) ? '0 : list_prev;
         pick  = $urandom_range(99);
         if (pick < 85) begin
            case (dvle_pkg::len_code_type'($urandom_range(3)))
               dvle_pkg::LEN_1_BYTE:  delta = 64'($urandom_range(63));
               dvle_pkg::LEN_2_BYTES: delta = 64'($urandom_range(16'h3fff, 64));
               dvle_pkg::LEN_4_BYTES:
                  delta = 64'($urandom_range(32'h3fff_ffff, 32'h4000));
               default: begin
                  delta = {$urandom, $urandom} >> $urandom_range(33, 2);
                  if (delta < 64'h4000_0000)
                     delta = delta | 64'h4000_0000;
               end
            endcase
            value = base + delta;
         end else begin
            case ($urandom_range(4))
               0: value = {$urandom, $urandom};
               1: value = ALL_ONES;
               2: value = base;
               3: value = base - 64'($urandom_range(1000));
               default: value = base + DELTA_LIMIT + 64'($urandom_range(1000));
            endcase
         end
         send_value(value, start);
      end
   endtask

   initial begin
      // Hold reset, then release it away from the active edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_random_lists(137, 21, 50);
      test_random_lists(137, 50, 21);
      test_random_lists(136, 0, 0);
      @(negedge clock);
      req_push <= 1'b0;

      // Drain, then watch a little longer for stray bytes.
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Sent %0d values, checked %0d encoded bytes in %0d cycles",
               values_sent, bytes_checked, cycle_count);
      $display("Rejected: %0d not increasing, %0d reserved, %0d delta too large",
               rejected_count[dvle_pkg::STATUS_NOT_INCREASING],
               rejected_count[dvle_pkg::STATUS_RESERVED],
               rejected_count[dvle_pkg::STATUS_TOO_LARGE]);
      if (fail_count == 0 && pending_bytes.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> delta_varint_list_encoder.f
src/dvle_pkg.sv
src/dvle_front.sv
src/dvle_queue.sv
src/dvle_back.sv
src/delta_varint_list_encoder.sv
test/delta_varint_list_encoder_tb.sv
